// File: hw/rtl/swbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swbb_pkg: shared constants and types of the sliding window byte buffer
// Sizes, command and status codes, and the request that the controller
// hands to the byte-lane memory array.
// ----------------------------------------------------------------------------
package swbb_pkg;

  // Ring size in bytes; must be a power of two (16 .. 1M)
  localparam int BUF_BYTES = 4096;
  // Largest transfer of one transaction (1 .. LANES)
  localparam int MAX_BYTES = 8;

  localparam int BYTE_W = 8;
  localparam int LANES  = 8;
  localparam int LANE_W = $clog2(LANES);
  localparam int DATA_W = LANES * BYTE_W;
  localparam int POS_W  = 48;
  localparam int CNT_W  = 4;
  localparam int STAT_W = 2;

  localparam int IDX_W  = $clog2(BUF_BYTES);
  localparam int FILL_W = IDX_W + 1;
  localparam int ROWS   = BUF_BYTES / LANES;

  localparam logic [POS_W:0]    POS_END  = {1'b1, {POS_W{1'b0}}};
  localparam logic [POS_W:0]    BUF_EXT  = (POS_W + 1)'(BUF_BYTES);
  localparam logic [FILL_W-1:0] BUF_FILL = FILL_W'(BUF_BYTES);
  localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_BYTES);

  // Command codes
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BEHIND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NODATA = 2'd2;

  // One access of the byte-lane array: up to LANES bytes from ring index idx
  typedef struct packed {
    logic              en;
    logic              wr;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  lump;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

endpackage

// File: hw/rtl/swbb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swbb_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module swbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register the read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hw/rtl/swbb_lanes.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swbb_lanes: byte-lane ring memory
// The ring is interleaved over LANES byte-wide RAMs, so that any run of up
// to LANES consecutive ring bytes touches each RAM at most once. Read bytes
// come back in the cycle after the request, rotated into transaction order.
// ----------------------------------------------------------------------------
module swbb_lanes import swbb_pkg::*; (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [DATA_W-1:0] rdata
);

  logic [BYTE_W-1:0] bank_rdata [LANES];
  logic              rd_q;
  logic [LANE_W-1:0] lo_q;
  logic [CNT_W-1:0]  lump_q;

  // One RAM per byte lane; lane offset picks the transaction byte
  for (genvar b = 0; b < LANES; b++) begin : g_bank
    logic [LANE_W-1:0] lane;
    logic [IDX_W-1:0]  addr;
    logic              act;

    assign lane = LANE_W'(b) - req.idx[LANE_W-1:0];
    assign act  = CNT_W'(lane) < req.lump;
    assign addr = req.idx + IDX_W'(lane);

    swbb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (req.en && req.wr && act),
      .addr  (addr[IDX_W-1:LANE_W]),
      .wdata (req.wdata[lane*BYTE_W +: BYTE_W]),
      .rdata (bank_rdata[b])
    );
  end

  // Hold the rotation and length of the access for the data cycle
  always_ff @(posedge clk) begin
    if (req.en) begin
      rd_q   <= !req.wr;
      lo_q   <= req.idx[LANE_W-1:0];
      lump_q <= req.lump;
    end
  end

  // Rotate bytes back into order, zero beyond the length and for writes
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rdata[i*BYTE_W +: BYTE_W] = (rd_q && (CNT_W'(i) < lump_q)) ?
                                  bank_rdata[lo_q + LANE_W'(i)] : '0;
    end
  end

endmodule

// File: hw/rtl/swbb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swbb_ctrl: window state and transaction sequencer
// Holds start, head, fill and stream length, walks each transaction through
// slide, head update, offset, ring index and memory access, and keeps the
// result register.
// ----------------------------------------------------------------------------
module swbb_ctrl import swbb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [POS_W-1:0]  position,
  input  logic [CNT_W-1:0]  byte_count,
  input  logic [DATA_W-1:0] write_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] read_data,
  output logic [CNT_W-1:0]  transferred,
  output logic [STAT_W-1:0] status,
  output logic [POS_W-1:0]  stream_length,
  output logic [POS_W-1:0]  window_start,
  output mem_req_t          mem_req,
  input  logic [DATA_W-1:0] mem_rdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SLIDE = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_ADDR  = 3'd3;
  localparam logic [2:0] S_INDEX = 3'd4;
  localparam logic [2:0] S_MEM   = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  // Control and window state
  logic [2:0]        state;
  logic [IDX_W-1:0]  head;
  logic [FILL_W-1:0] fill;
  logic [POS_W-1:0]  start;
  logic [POS_W:0]    length;

  // Transaction registers
  logic              cmd;
  logic [POS_W-1:0]  pos;
  logic [CNT_W-1:0]  len;
  logic [POS_W:0]    end_pos;
  logic              behind;
  logic [DATA_W-1:0] wdata;
  logic              over;
  logic              slide_big;
  logic [FILL_W-1:0] slide_lo;
  logic [FILL_W-1:0] off;
  logic              nodata;
  logic [IDX_W-1:0]  idx;
  logic [FILL_W-1:0] room;
  logic [CNT_W-1:0]  len_r;
  logic [CNT_W-1:0]  lump;

  // Combinational values
  logic [CNT_W-1:0]  len_sat;
  logic [POS_W:0]    in_end;
  logic              in_clip;
  logic              in_behind;
  logic [POS_W:0]    clip_len;
  logic [POS_W:0]    lim;
  logic [POS_W:0]    slide;
  logic [POS_W:0]    start_slid;
  logic [POS_W:0]    diff;
  logic [FILL_W-1:0] sum_i;
  logic [FILL_W-1:0] avail;
  logic [CNT_W-1:0]  lump_c;
  logic              do_wr;
  logic [POS_W:0]    len_cand;
  logic [POS_W:0]    length_next;
  logic [FILL_W-1:0] off_end;
  logic [FILL_W-1:0] fill_next;
  logic              load;

  assign in_ready = (state == S_IDLE);
  assign load     = (state == S_RESP) && (!out_valid || out_ready);

  // Saturate the count and cut writes at the top of the position space
  assign len_sat   = (byte_count > MAX_CNT) ? MAX_CNT : byte_count;
  assign in_end    = {1'b0, position} + (POS_W + 1)'(len_sat);
  assign in_clip   = in_end > POS_END;
  assign clip_len  = POS_END - {1'b0, position};
  assign in_behind = position < start;

  // Slide of the window past its end
  assign lim        = {1'b0, start} + BUF_EXT;
  assign slide      = end_pos - lim;
  assign start_slid = end_pos - BUF_EXT;

  // Offset into the window and ring index
  assign diff  = {1'b0, pos} - {1'b0, start};
  assign sum_i = {1'b0, head} + off;
  assign avail = fill - off;

  // Bytes moved: zero if rejected or no data, else clamp to room to ring end
  always_comb begin
    if ((cmd == CMD_WRITE && behind) || nodata) begin
      lump_c = '0;
    end else if (FILL_W'(len_r) > room) begin
      lump_c = room[CNT_W-1:0];
    end else begin
      lump_c = len_r;
    end
  end

  // Fill and stream length after a write
  assign do_wr       = (cmd == CMD_WRITE) && !behind && (lump != '0);
  assign len_cand    = {1'b0, pos} + (POS_W + 1)'(lump);
  assign length_next = (do_wr && len_cand > length) ? len_cand : length;
  assign off_end     = off + FILL_W'(lump);
  assign fill_next   = (do_wr && off_end > fill) ? off_end : fill;

  // Memory access issued in the access step
  always_comb begin
    mem_req.en    = (state == S_MEM);
    mem_req.wr    = (cmd == CMD_WRITE) && !behind;
    mem_req.idx   = idx;
    mem_req.lump  = lump_c;
    mem_req.wdata = wdata;
  end

  // Sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      fill      <= '0;
      start     <= '0;
      length    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd    <= command;
            wdata  <= write_data;
            behind <= in_behind;
            if ((command == CMD_WRITE) && in_clip) begin
              len     <= clip_len[CNT_W-1:0];
              end_pos <= POS_END;
            end else begin
              len     <= len_sat;
              end_pos <= in_end;
            end
            if (command == CMD_WRITE) begin
              pos <= position;
            end else begin
              pos <= in_behind ? start : position;
            end
            state <= S_SLIDE;
          end
        end
        S_SLIDE: begin
          over      <= (cmd == CMD_WRITE) && !behind && (end_pos > lim);
          slide_big <= |slide[POS_W:FILL_W];
          slide_lo  <= slide[FILL_W-1:0];
          if ((cmd == CMD_WRITE) && !behind && (end_pos > lim)) begin
            start <= start_slid[POS_W-1:0];
          end
          state <= S_HEAD;
        end
        S_HEAD: begin
          if (over) begin
            if (slide_big || slide_lo >= fill) begin
              head <= '0;
              fill <= '0;
            end else begin
              head <= head + slide_lo[IDX_W-1:0];
              fill <= fill - slide_lo;
            end
          end
          state <= S_ADDR;
        end
        S_ADDR: begin
          off    <= diff[FILL_W-1:0];
          nodata <= (cmd == CMD_READ) &&
                    ((|diff[POS_W:FILL_W]) || (diff[FILL_W-1:0] >= fill));
          state  <= S_INDEX;
        end
        S_INDEX: begin
          idx <= sum_i[IDX_W-1:0];
          if (sum_i[IDX_W]) begin
            room <= {1'b0, head} - {1'b0, sum_i[IDX_W-1:0]};
          end else begin
            room <= BUF_FILL - {1'b0, sum_i[IDX_W-1:0]};
          end
          if ((cmd == CMD_READ) && (FILL_W'(len) > avail)) begin
            len_r <= avail[CNT_W-1:0];
          end else begin
            len_r <= len;
          end
          state <= S_MEM;
        end
        S_MEM: begin
          lump  <= lump_c;
          state <= S_RESP;
        end
        S_RESP: begin
          if (load) begin
            fill      <= fill_next;
            length    <= length_next;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      read_data     <= mem_rdata;
      transferred   <= lump;
      stream_length <= length_next[POS_W-1:0];
      window_start  <= start;
      if ((cmd == CMD_WRITE) && behind) begin
        status <= STAT_BEHIND;
      end else if (nodata) begin
        status <= STAT_NODATA;
      end else begin
        status <= STAT_OK;
      end
    end
  end

endmodule

// File: hw/rtl/sliding_window_byte_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_byte_buffer: ring store over the newest bytes of a stream
// Each transaction reads or writes up to 8 bytes at an absolute stream
// position; a write past the window end slides the window forward. One
// transaction is handled at a time: the controller walks it through slide,
// head update, offset, ring index and the registered read of the byte-lane
// RAMs, then registers the result once the last result has been taken, and
// takes the next input in the cycle after that. The ring RAMs need no
// clearing after reset; bytes of the ring never written read as undefined.
// ----------------------------------------------------------------------------
module sliding_window_byte_buffer import swbb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [POS_W-1:0]  position,
  input  logic [CNT_W-1:0]  byte_count,
  input  logic [DATA_W-1:0] write_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] read_data,
  output logic [CNT_W-1:0]  transferred,
  output logic [STAT_W-1:0] status,
  output logic [POS_W-1:0]  stream_length,
  output logic [POS_W-1:0]  window_start
);

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;

  // Window state and sequencing
  swbb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .position      (position),
    .byte_count    (byte_count),
    .write_data    (write_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_data     (read_data),
    .transferred   (transferred),
    .status        (status),
    .stream_length (stream_length),
    .window_start  (window_start),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata)
  );

  // Ring bytes
  swbb_lanes u_lanes (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

// File: hw/rtl/swbb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swbb_checker: port-level checks of the sliding window byte buffer
// Watches the result channel: rejected and empty transactions move no data,
// the window start and stream length never move back, stalled results hold.
// ----------------------------------------------------------------------------
module swbb_checker import swbb_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] read_data,
  input logic [CNT_W-1:0]  transferred,
  input logic [STAT_W-1:0] status,
  input logic [POS_W-1:0]  stream_length,
  input logic [POS_W-1:0]  window_start
);

  logic             seen;
  logic [POS_W-1:0] last_start;
  logic [POS_W-1:0] last_length;

  // Track the last delivered window start and stream length
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen        <= 1'b1;
      last_start  <= window_start;
      last_length <= stream_length;
    end
  end

  // A rejected write moves no data
  a_behind_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_BEHIND |-> transferred == '0 && read_data == '0)
    else $error("rejected write reports transferred bytes");

  // A read past the data returns nothing
  a_nodata_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_NODATA |-> transferred == '0 && read_data == '0)
    else $error("read without data reports transferred bytes");

  // The window only slides forward
  a_start_mono: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && seen |-> window_start >= last_start)
    else $error("window start moved back");

  // The stream only grows; its length wraps to zero at the top of the
  // position space
  a_length_mono: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && seen |->
    stream_length >= last_length || stream_length == '0)
    else $error("stream length moved back");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) &&
    $stable(transferred) && $stable(status))
    else $error("result changed while stalled");

endmodule

bind sliding_window_byte_buffer swbb_checker u_swbb_checker (.*);
